[sv/assert_macros.svh]
// Assertion macros for the RTL that carries checks; only the top level includes them.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, gated by reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/nci_pkg.sv]
// Package of the Newton cubic root iterator: types, codes and saturation helpers.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package nci_pkg;

   localparam int MAX_ITER_DEF = 32;
   localparam int ROW_CAP      = 32;
   localparam int STEP_W       = 7;
   localparam int DIV_STEPS    = 33;
   localparam int TOL_RESET    = 66;

   typedef enum logic [1:0] {
      CODE_CONT  = 2'd0,
      CODE_CONV  = 2'd1,
      CODE_ZERO  = 2'd2,
      CODE_LIMIT = 2'd3
   } row_code_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_GO, ST_SQ_WAIT, ST_CU_GO, ST_CU_WAIT, ST_EVAL,
      ST_CHECK, ST_DIV_GO, ST_DIV_RUN, ST_Y_SET, ST_DECIDE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic              load_start;
      logic              mul_start;
      logic              mul_cube;
      logic              latch_fx;
      logic              latch_fy;
      logic              div_start;
      logic              y_set;
      logic              row_load;
      logic              advance;
      row_code_type      code;
      logic              last;
      logic [STEP_W-1:0] step;
   } nci_cmd_type;

   typedef struct packed {
      logic d_zero;
      logic conv;
      logic div_done;
      logic out_free;
   } nci_stat_type;

   // Clamp a signed 64-bit value to the signed 48-bit range
   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< 47) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi[47:0];
      else if (v < lo) return lo[47:0];
      else return v[47:0];
   endfunction

   // Clamp a signed 48-bit value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = (48'sd1 <<< 31) - 48'sd1;
      lo = -hi - 48'sd1;
      if (v > hi) return hi[31:0];
      else if (v < lo) return lo[31:0];
      else return v[31:0];
   endfunction

endpackage
`default_nettype wire

[sv/nci_ctrl.sv]
// Sequencer of the Newton cubic root iterator: steps the datapath through each iteration.
// Depends on nci_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nci_ctrl #(
   parameter int MAX_ITER = nci_pkg::MAX_ITER_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire nci_pkg::nci_stat_type stat,
   output nci_pkg::nci_cmd_type      cmd
);
   import nci_pkg::*;

   localparam int LIMIT = (MAX_ITER < ROW_CAP) ? MAX_ITER : ROW_CAP;

   state_type         state_ff, state_in;
   logic              eval_y_ff, eval_y_in;
   logic [STEP_W-1:0] step_ff, step_in;
   row_code_type      code_ff, code_in;
   logic              last_ff, last_in;

   // State and run registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         eval_y_ff <= 1'b0;
         step_ff   <= '0;
         code_ff   <= CODE_CONT;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         eval_y_ff <= eval_y_in;
         step_ff   <= step_in;
         code_ff   <= code_in;
         last_ff   <= last_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      eval_y_in  = eval_y_ff;
      step_in    = step_ff;
      code_in    = code_ff;
      last_in    = last_ff;
      cmd        = '0;
      cmd.code   = code_ff;
      cmd.last   = last_ff;
      cmd.step   = step_ff;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_start = 1'b1;
               step_in        = STEP_W'(1);
               eval_y_in      = 1'b0;
               state_in       = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: state_in = ST_CU_GO;
         ST_CU_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_cube  = 1'b1;
            state_in      = ST_CU_WAIT;
         end
         ST_CU_WAIT: state_in = ST_EVAL;
         ST_EVAL: begin
            cmd.latch_fx = !eval_y_ff;
            cmd.latch_fy = eval_y_ff;
            state_in     = eval_y_ff ? ST_DECIDE : ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.d_zero) begin
               code_in  = CODE_ZERO;
               last_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (stat.div_done) state_in = ST_Y_SET;
         end
         ST_Y_SET: begin
            cmd.y_set = 1'b1;
            eval_y_in = 1'b1;
            state_in  = ST_SQ_GO;
         end
         ST_DECIDE: begin
            if (stat.conv) begin
               code_in = CODE_CONV;
               last_in = 1'b1;
            end else if (step_ff >= STEP_W'(LIMIT)) begin
               code_in = CODE_LIMIT;
               last_in = 1'b1;
            end else begin
               code_in = CODE_CONT;
               last_in = 1'b0;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.row_load = 1'b1;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  step_in     = step_ff + STEP_W'(1);
                  eval_y_in   = 1'b0;
                  state_in    = ST_SQ_GO;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[sv/nci_dpath.sv]
// Datapath of the Newton cubic root iterator: multiplier, polynomial, divider, result word.
// Depends on nci_pkg; driven by nci_ctrl through command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module nci_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [31:0]           start_value,
   input  wire logic                  csr_valid,
   input  wire logic [30:0]           csr_data,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [135:0]               rsp_tdata,
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast,
   input  wire nci_pkg::nci_cmd_type  cmd,
   output nci_pkg::nci_stat_type      stat
);
   import nci_pkg::*;

   logic [30:0]        tol_ff;
   logic signed [31:0] x_ff, y_ff, ev_ff;
   logic signed [47:0] sq_ff, cu_ff, fx_ff, d_ff, fy_ff;
   logic signed [64:0] p0_ff;
   logic signed [47:0] p1_ff;
   logic               mbusy_ff, mcube_ff;
   logic [47:0]        ud_ff, rem_ff;
   logic [32:0]        nq_ff;
   logic [5:0]         dcnt_ff;
   logic               neg_ff, clamp_ff;
   logic               ovalid_ff;
   logic [135:0]       odata_ff;
   logic [1:0]         ouser_ff;
   logic               olast_ff;

   // Multiplier operands and partial products
   logic signed [47:0] mul_a;
   logic signed [64:0] p0_in;
   logic signed [47:0] p1_in;
   logic signed [79:0] full;
   logic signed [47:0] mres;
   assign mul_a = cmd.mul_cube ? sq_ff : {{16{ev_ff[31]}}, ev_ff};
   assign p0_in = $signed({1'b0, mul_a[31:0]}) * ev_ff;
   assign p1_in = $signed(mul_a[47:32]) * ev_ff;
   assign full  = $signed({p1_ff, 32'd0}) + {{15{p0_ff[64]}}, p0_ff} + 80'sd32768;
   assign mres  = sat48(full[79:16]);

   // Polynomial and derivative
   logic signed [51:0] ev52, sq52, cu52, fsum, dsum;
   logic signed [47:0] fval, dval;
   assign ev52 = {{20{ev_ff[31]}}, ev_ff};
   assign sq52 = {{4{sq_ff[47]}}, sq_ff};
   assign cu52 = {{4{cu_ff[47]}}, cu_ff};
   assign fsum = cu52 + sq52 - 52'sd3 * ev52 - 52'sd196608;
   assign dsum = 52'sd3 * sq52 + 52'sd2 * ev52 - 52'sd196608;
   assign fval = sat48({{12{fsum[51]}}, fsum});
   assign dval = sat48({{12{dsum[51]}}, dsum});

   // Divider set-up and restoring step
   logic [47:0] uf, ud;
   logic [48:0] trial;
   logic        qbit;
   assign uf    = fx_ff[47] ? 48'(-fx_ff) : 48'(fx_ff);
   assign ud    = d_ff[47] ? 48'(-d_ff) : 48'(d_ff);
   assign trial = {rem_ff, nq_ff[32]};
   assign qbit  = (trial >= {1'b0, ud_ff});

   // New estimate from the quotient
   logic [33:0]        q34;
   logic signed [34:0] sq35;
   logic signed [35:0] diff;
   logic signed [31:0] ynew;
   assign q34  = clamp_ff ? 34'h2_0000_0000 : {1'b0, nq_ff};
   assign sq35 = neg_ff ? -$signed({1'b0, q34}) : $signed({1'b0, q34});
   assign diff = {{4{x_ff[31]}}, x_ff} - {sq35[34], sq35};
   assign ynew = sat32({{12{diff[35]}}, diff});

   // Convergence test on the 48-bit residual, before its saturation to 32 bits
   logic [47:0] afy;
   assign afy = fy_ff[47] ? 48'(-fy_ff) : 48'(fy_ff);

   assign stat.d_zero   = (d_ff == '0);
   assign stat.conv     = (afy <= {17'd0, tol_ff});
   assign stat.div_done = (dcnt_ff == '0);
   assign stat.out_free = !ovalid_ff || rsp_tready;

   // Control registers: tolerance, multiplier phase, divider count, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff    <= 31'(TOL_RESET);
         mbusy_ff  <= 1'b0;
         mcube_ff  <= 1'b0;
         dcnt_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (csr_valid) tol_ff <= csr_data;
         mbusy_ff <= cmd.mul_start;
         if (cmd.mul_start) mcube_ff <= cmd.mul_cube;
         if (cmd.div_start) dcnt_ff <= 6'(DIV_STEPS);
         else if (dcnt_ff != '0) dcnt_ff <= dcnt_ff - 6'd1;
         if (cmd.row_load) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         x_ff  <= start_value;
         ev_ff <= start_value;
      end else if (cmd.y_set) begin
         y_ff  <= ynew;
         ev_ff <= ynew;
      end else if (cmd.advance) begin
         x_ff  <= y_ff;
         ev_ff <= y_ff;
      end
      if (cmd.mul_start) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
      end
      if (mbusy_ff) begin
         if (mcube_ff) cu_ff <= mres;
         else sq_ff <= mres;
      end
      if (cmd.latch_fx) begin
         fx_ff <= fval;
         d_ff  <= dval;
      end
      if (cmd.latch_fy) fy_ff <= fval;
      if (cmd.div_start) begin
         ud_ff    <= ud;
         neg_ff   <= fx_ff[47] != d_ff[47];
         clamp_ff <= ({17'd0, uf} >= {ud, 17'd0});
         rem_ff   <= {17'd0, uf[47:17]};
         nq_ff    <= {uf[16:0], 16'd0};
      end else if (dcnt_ff != '0) begin
         rem_ff <= qbit ? 48'(trial - {1'b0, ud_ff}) : trial[47:0];
         nq_ff  <= {nq_ff[31:0], qbit};
      end
      if (cmd.row_load) begin
         odata_ff[6:0]    <= cmd.step;
         odata_ff[38:7]   <= x_ff;
         odata_ff[70:39]  <= (cmd.code == CODE_ZERO) ? 32'd0 : y_ff;
         odata_ff[102:71] <= sat32(fx_ff);
         odata_ff[134:103] <= (cmd.code == CODE_ZERO) ? 32'd0 : sat32(fy_ff);
         odata_ff[135]    <= 1'b0;
         ouser_ff         <= cmd.code;
         olast_ff         <= cmd.last;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;
   assign rsp_tlast  = olast_ff;

endmodule
`default_nettype wire

[sv/newton_cubic_root_iterator.sv]
// Top level of the Newton cubic root iterator: joins the sequencer and the datapath.
// Depends on nci_pkg, nci_ctrl, nci_dpath and assert_macros.svh.
//
// Use: a start word on req_ (tdata[31:0] = x0, signed Q16.16) starts one run of
// Newton-Raphson on x^3 + x^2 - 3x - 3. Each iteration yields one word on rsp_;
// the run ends on convergence (|f(y)| <= tolerance), a zero derivative or the
// step limit, and that word carries tlast. csr_ writes the 31-bit tolerance
// (reset value 66); write only while no run is in progress.
// Each iteration squares and cubes x, runs the divider's 33 restoring steps, then
// squares and cubes y; a run gives at most 32 rows at the default step limit.
// req_tready is high only between runs; one run is worked at a time.
// A stalled rsp_ word holds in the output register; the sequencer waits for it
// to be taken before loading the next row.
// Reset clears the sequencer, the output valid and sets the tolerance to 66.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module newton_cubic_root_iterator #(
   parameter int MAX_ITER = nci_pkg::MAX_ITER_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // [31:0] start_value
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [6:0] step_index, [38:7] old_estimate, [70:39] new_estimate,
   // [102:71] residual_old, [134:103] residual_new, [135] zero
   output logic [135:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser,   // [1:0] status
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [30:0]  csr_data     // [30:0] tolerance
);
   import nci_pkg::*;

   localparam int LIMIT = (MAX_ITER < ROW_CAP) ? MAX_ITER : ROW_CAP;

   nci_cmd_type  cmd;
   nci_stat_type stat;

   assign csr_ready = 1'b1;

   nci_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   nci_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .start_value (req_tdata),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .stat        (stat)
   );

   // Busy once a start word is taken
   `ASSERT_NEXT(a_busy_after_start, clock, reset, req_tvalid && req_tready, !req_tready)
   // Any ending status closes the run
   `ASSERT_IMPL(a_end_is_last, clock, reset, rsp_tvalid && (rsp_tuser != CODE_CONT), rsp_tlast)
   // Zero derivative rows carry a zero estimate
   `ASSERT_IMPL(a_zero_row, clock, reset, rsp_tvalid && (rsp_tuser == CODE_ZERO), rsp_tdata[70:39] == 32'd0)
   // Step index stays within the limit
   `ASSERT_IMPL(a_step_range, clock, reset, rsp_tvalid, (rsp_tdata[6:0] != 7'd0) && (rsp_tdata[6:0] <= 7'(LIMIT)))

endmodule
`default_nettype wire

[test/testbench.sv]
// Testbench of the Newton cubic root iterator: start words in, one row per iteration out.
// Depends on nci_pkg and newton_cubic_root_iterator; rows are checked against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import nci_pkg::*;

   typedef struct {
      logic [6:0]   step;
      logic [31:0]  old_x;
      logic [31:0]  new_x;
      logic [31:0]  f_old;
      logic [31:0]  f_new;
      row_code_type code;
      logic         last;
   } row_type;

   typedef struct {
      logic [31:0] start;
      bit          typed;
      row_type     row;
   } dir_row_type;

   localparam int  RUN_CAP    = (MAX_ITER_DEF < ROW_CAP) ? MAX_ITER_DEF : ROW_CAP;
   localparam int  IDLE_LIMIT = 20000;
   localparam int  LONG_HOLD  = 3000;
   localparam longint ONE     = 65536;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [30:0]   csr_data = '0;

   row_type       expected_rows[$];
   logic [30:0]   tolerance_model;
   int            mismatches = 0;
   int            burst_left = 0;
   int            hold_left = 0;
   bit            hold_request = 0;
   int            idle_cycles = 0;
   longint        zero_slope_x;
   bit            zero_slope_found = 0;

   newton_cubic_root_iterator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // ---- cubic Newton predictor ----
   function automatic longint clamp_bits(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // rounded Q16.16 product, split so it stays within 64 bits
   function automatic longint fixed_product(longint a, longint b);
      longint ah;
      longint al;
      longint lo;
      ah = a >>> 16;
      al = a - ah * ONE;
      lo = (al * b + 32768) >>> 16;
      return clamp_bits(ah * b + lo, 48);
   endfunction

   function automatic longint cubic_value(longint x, output longint slope);
      longint x2;
      longint x3;
      x2 = fixed_product(x, x);
      x3 = fixed_product(x2, x);
      slope = clamp_bits(3 * x2 + 2 * x - 3 * ONE, 48);
      return clamp_bits(x3 + x2 - 3 * x - 3 * ONE, 48);
   endfunction

   function automatic longint newton_quotient(longint f, longint d);
      bit neg;
      longint unsigned uf;
      longint unsigned ud;
      longint unsigned ip;
      longint unsigned q;
      longint unsigned lim;
      neg = (f < 0) != (d < 0);
      uf  = (f < 0) ? -f : f;
      ud  = (d < 0) ? -d : d;
      lim = 64'd1 << 33;
      ip  = uf / ud;
      if (ip >= (64'd1 << 17)) q = lim;
      else q = (ip << 16) + (((uf % ud) << 16) / ud);
      if (q > lim) q = lim;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // Work out every row of one run and queue them
   task automatic predict_run(logic [31:0] start);
      longint  x;
      longint  y;
      longint  fx;
      longint  fy;
      longint  d;
      longint  ay;
      longint  unused;
      row_type r;
      int      n;
      bit      done;
      x = longint'($signed(start));
      n = 0;
      done = 0;
      while (!done) begin
         fx = cubic_value(x, d);
         y = 0;
         fy = 0;
         n++;
         if (d == 0) begin
            r.code = CODE_ZERO;
            done = 1;
         end else begin
            y = clamp_bits(x - newton_quotient(fx, d), 32);
            fy = cubic_value(y, unused);
            ay = (fy < 0) ? -fy : fy;
            if (ay <= longint'(tolerance_model)) begin
               r.code = CODE_CONV;
               done = 1;
            end else if (n >= RUN_CAP) begin
               r.code = CODE_LIMIT;
               done = 1;
            end else begin
               r.code = CODE_CONT;
            end
         end
         r.step  = n[6:0];
         r.old_x = x[31:0];
         r.new_x = y[31:0];
         r.f_old = 32'(clamp_bits(fx, 32));
         r.f_new = 32'(clamp_bits(fy, 32));
         r.last  = done;
         expected_rows.push_back(r);
         if (r.code != CODE_ZERO) x = y;
      end
   endtask

   // ---- stimulus side ----
   task automatic send_start(logic [31:0] v, bit typed, row_type typed_row);
      int g;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (g > 0) begin
            req_tvalid <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      if (typed) expected_rows.push_back(typed_row);
      else predict_run(v);
   endtask

   // Write the tolerance once the block has drained
   task automatic write_tolerance(logic [30:0] tol);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_rows.size() == 0);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= tol;
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      tolerance_model = tol;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_start();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      if (sel < 9) return $urandom;
      return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
   endfunction

   task automatic send_random(int count);
      row_type none;
      none = '{code: CODE_CONT, default: '0};
      for (int i = 0; i < count; i++) send_start(random_start(), 0, none);
   endtask

   // ---- receiver: stall pattern and long hold-off ----
   always @(negedge clock) begin : rx_side
      bit r;
      int phase;
      phase = ($time / 2000) % 3;
      if (hold_request) begin
         hold_left = LONG_HOLD;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         r = 1'b0;
         hold_left--;
      end else if (phase == 0) r = 1'b1;
      else if (phase == 1) r = ($urandom_range(0, 3) != 0);
      else r = ($urandom_range(0, 3) == 0);
      rsp_tready <= r;
   end

   // Check each row word at the edge that takes it
   always @(posedge clock) begin : rx_check
      row_type e;
      row_type a;
      if (!reset && rsp_tready && rsp_tvalid) begin
         a.step  = rsp_tdata[6:0];
         a.old_x = rsp_tdata[38:7];
         a.new_x = rsp_tdata[70:39];
         a.f_old = rsp_tdata[102:71];
         a.f_new = rsp_tdata[134:103];
         a.code  = row_code_type'(rsp_tuser);
         a.last  = rsp_tlast;
         if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected row: step %0d x %h", a.step, a.old_x);
         end else begin
            e = expected_rows.pop_front();
            if (e.step !== a.step || e.old_x !== a.old_x || e.new_x !== a.new_x ||
                e.f_old !== a.f_old || e.f_new !== a.f_new || e.code !== a.code ||
                e.last !== a.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("row mismatch exp %0d %h %h %h %h %s %b got %0d %h %h %h %h %s %b",
                     e.step, e.old_x, e.new_x, e.f_old, e.f_new, e.code.name(), e.last,
                     a.step, a.old_x, a.new_x, a.f_old, a.f_new, a.code.name(), a.last);
            end
         end
      end
   end

   // Watchdog: cycles without any word moving
   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (!reset && idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---- main sequence ----
   initial begin : main_seq
      dir_row_type dir_table[$];
      dir_row_type t;
      longint      d;
      row_type     none;

      none = '{code: CODE_CONT, default: '0};
      tolerance_model = 31'(TOL_RESET);

      // find an estimate whose derivative is exactly zero, near either turning point
      for (longint x = 30000; x < 60000 && !zero_slope_found; x++) begin
         void'(cubic_value(x, d));
         if (d == 0) begin
            zero_slope_x = x;
            zero_slope_found = 1;
         end
      end
      for (longint x = -110000; x < -80000 && !zero_slope_found; x++) begin
         void'(cubic_value(x, d));
         if (d == 0) begin
            zero_slope_x = x;
            zero_slope_found = 1;
         end
      end

      // directed table; the first two rows are plain to read off
      t.typed = 1;
      t.start = 32'd0;
      t.row = '{7'd1, 32'd0, 32'hFFFF_0000, 32'hFFFD_0000, 32'd0, CODE_CONV, 1'b1};
      dir_table.push_back(t);
      t.start = 32'hFFFF_0000;
      t.row = '{7'd1, 32'hFFFF_0000, 32'hFFFF_0000, 32'd0, 32'd0, CODE_CONV, 1'b1};
      dir_table.push_back(t);
      t.typed = 0;
      t.row = none;
      for (int i = 0; i < 13; i++) begin
         t.start = (i == 0) ? 32'h7FFF_FFFF : (i == 1) ? 32'h8000_0000 : (i == 2) ? 32'd1 :
                   (i == 3) ? 32'hFFFF_FFFF : (i == 4) ? 32'h0001_0000 :
                   (i == 5) ? 32'h0002_0000 : (i == 6) ? 32'h0001_BB68 :
                   (i == 7) ? 32'hFFFE_4498 : (i == 8) ? 32'h5555_5555 :
                   (i == 9) ? 32'hAAAA_AAAA : (i == 10) ? 32'h0064_0000 :
                   (i == 11) ? 32'hFF9C_0000 : 32'h0000_B886;
         dir_table.push_back(t);
      end
      if (zero_slope_found) begin
         t.start = zero_slope_x[31:0];
         dir_table.push_back(t);
      end

      // hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset tolerance
      foreach (dir_table[i]) send_start(dir_table[i].start, dir_table[i].typed, dir_table[i].row);

      // zero tolerance: mostly step-limit runs; rerun the extremes
      write_tolerance(31'd0);
      send_start(32'h7FFF_FFFF, 0, none);
      send_start(32'h8000_0000, 0, none);
      if (zero_slope_found) send_start(zero_slope_x[31:0], 0, none);
      send_random(15);

      // widest tolerance: a run converges on its first row unless |f(y)| exceeds it or the slope is zero
      write_tolerance(31'h7FFF_FFFF);
      send_random(15);

      // mid settings, with one long receiver hold-off to back the block up
      write_tolerance(31'd1);
      send_random(10);
      hold_request = 1;
      send_random(20);
      for (int p = 0; p < 6; p++) begin
         write_tolerance(($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4096)));
         send_random(13);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_rows.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_rows.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/nci_pkg.sv
sv/nci_ctrl.sv
sv/nci_dpath.sv
sv/newton_cubic_root_iterator.sv
test/testbench.sv
